[rtl/core/preemptive_priority_scheduler_assert.svh]
// Assertion macros used by the scheduler RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define PPSCH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scheduler assertion failed");
// Condition must never be true outside reset.
`define PPSCH_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("scheduler forbidden condition seen");
`else
`define PPSCH_ASSERT(lbl, clk, rst_n, prop)
`define PPSCH_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[rtl/core/ppsch_pkg.sv]
package ppsch_pkg;

    // Default number of ready queue entries.
    localparam int Q_DEPTH_DEFAULT = 16;

    // Event codes.
    localparam logic OP_ARRIVE   = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } t_state;

    // Input transaction.
    typedef struct packed {
        logic        opcode;
        logic [31:0] now;
        logic [15:0] new_id;
        logic [31:0] new_arrival;
        logic [15:0] new_total;
        logic [7:0]  new_priority;
    } t_in;

    // Result transaction.
    typedef struct packed {
        logic        running_valid;
        logic [15:0] running_id;
        logic [31:0] running_arrival;
        logic [15:0] running_total;
        logic [31:0] running_start;
        logic [31:0] running_end;
        logic [15:0] running_remaining;
        logic [7:0]  running_priority;
        logic [4:0]  queue_count;
        logic        overflow;
    } t_out;

    // One process record as held in a queue cell.
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [15:0] total;
        logic [15:0] remaining;
        logic [7:0]  prio;
    } t_entry;

    // Minimum search token passed from cell to cell.
    typedef struct packed {
        logic   found;
        t_entry entry;
    } t_tok;

    // Queue update command broadcast to all cells.
    typedef struct packed {
        logic push;
        logic shift;
    } t_qcmd;

endpackage

[rtl/core/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler. Each input transaction is one event (an
// arrival or a completion) and yields one result transaction: the running
// record after the event, the ready queue fill and a drop flag. The ready
// queue is a row of QUEUE_DEPTH cells; a search token crosses the row one
// cell per clock to find the first entry of lowest priority value. An
// arrival's result is registered at the edge that accepts it. A completion
// enters the search state while the token travels the cell row, then the
// commit state, where its result is registered once the result register
// is free. The next event is accepted once the block is back in its idle
// state and the result register is empty or being emptied, so a result
// left waiting adds its wait to the next acceptance. No reset sweep is
// needed: queue entries are only read below the fill count.
module preemptive_priority_scheduler
    import ppsch_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    `include "preemptive_priority_scheduler_assert.svh"

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] L_FULL  = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] L_WLAST = CW'(QUEUE_DEPTH - 1);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_wait;
    logic [CW-1:0] n_wait;
    logic [31:0]   r_now;
    logic [31:0]   n_now;
    logic          r_cur_valid;
    logic          n_cur_valid;
    t_entry        r_cur;
    t_entry        n_cur;
    logic [31:0]   r_cur_start;
    logic [31:0]   n_cur_start;
    logic [31:0]   r_cur_end;
    logic [31:0]   n_cur_end;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;
    t_out          r_out;
    t_out          n_out;

    logic          w_slot_free;
    logic          w_accept;
    logic          w_commit;
    logic          w_ovf;
    logic [31:0]   w_elapsed;
    logic [15:0]   w_rem;
    t_entry        w_new;
    t_entry        w_push_entry;
    t_qcmd         w_cmd;

    t_tok          w_tok     [QUEUE_DEPTH+1];
    logic [IW-1:0] w_tok_idx [QUEUE_DEPTH+1];
    t_entry        w_ent     [QUEUE_DEPTH];

    // Handshake qualifiers.
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_commit    = (r_state == S_COMMIT) && w_slot_free;

    // Cell row with the search token chained through it.
    assign w_tok[0]     = '0;
    assign w_tok_idx[0] = '0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_next;
        if (g < QUEUE_DEPTH - 1) begin : g_mid
            assign w_next = w_ent[g+1];
        end else begin : g_last
            assign w_next = w_ent[g];
        end
        ppsch_cell #(
            .DEPTH (QUEUE_DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_count      (r_count),
            .i_sel_idx    (w_tok_idx[QUEUE_DEPTH]),
            .i_push_entry (w_push_entry),
            .i_next_entry (w_next),
            .o_entry      (w_ent[g]),
            .i_tok        (w_tok[g]),
            .i_tok_idx    (w_tok_idx[g]),
            .o_tok        (w_tok[g+1]),
            .o_tok_idx    (w_tok_idx[g+1])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in.opcode == OP_COMPLETE)) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_wait == L_WLAST) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Preempted process: elapsed time taken off its remaining time, saturating at zero.
    assign w_elapsed = i_in.now - r_cur_start;
    assign w_rem     = (w_elapsed >= {16'd0, r_cur.remaining}) ? 16'd0 :
                       (r_cur.remaining - w_elapsed[15:0]);

    assign w_new.id        = i_in.new_id;
    assign w_new.arrival   = i_in.new_arrival;
    assign w_new.total     = i_in.new_total;
    assign w_new.remaining = i_in.new_total;
    assign w_new.prio      = i_in.new_priority;

    // Event processing, queue commands and the result.
    always_comb begin
        n_wait       = r_wait;
        n_now        = r_now;
        n_cur_valid  = r_cur_valid;
        n_cur        = r_cur;
        n_cur_start  = r_cur_start;
        n_cur_end    = r_cur_end;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_out_ready;
        w_cmd        = '0;
        w_ovf        = 1'b0;
        w_push_entry = w_new;

        case (r_state)
            S_IDLE: begin
                n_wait = '0;
                n_now  = i_in.now;
                if (w_accept && (i_in.opcode == OP_ARRIVE)) begin
                    if (!r_cur_valid) begin
                        n_cur_valid = 1'b1;
                        n_cur       = w_new;
                        n_cur_start = i_in.now;
                        n_cur_end   = i_in.now + {16'd0, i_in.new_total};
                    end else if (r_count == L_FULL) begin
                        w_ovf = 1'b1;
                    end else if (i_in.new_priority >= r_cur.prio) begin
                        w_cmd.push = 1'b1;
                        n_count    = r_count + 1'b1;
                    end else begin
                        w_cmd.push             = 1'b1;
                        w_push_entry           = r_cur;
                        w_push_entry.remaining = w_rem;
                        n_count                = r_count + 1'b1;
                        n_cur                  = w_new;
                        n_cur_start            = i_in.now;
                        n_cur_end              = i_in.now + {16'd0, i_in.new_total};
                    end
                    n_out_valid = 1'b1;
                end
            end
            S_SEARCH: begin
                n_wait = r_wait + 1'b1;
            end
            S_COMMIT: begin
                if (w_slot_free) begin
                    if (w_tok[QUEUE_DEPTH].found) begin
                        w_cmd.shift = 1'b1;
                        n_count     = r_count - 1'b1;
                        n_cur_valid = 1'b1;
                        n_cur       = w_tok[QUEUE_DEPTH].entry;
                        n_cur_start = r_now;
                        n_cur_end   = r_now + {16'd0, w_tok[QUEUE_DEPTH].entry.remaining};
                    end else begin
                        n_cur_valid = 1'b0;
                        n_cur       = '0;
                        n_cur_start = '0;
                        n_cur_end   = '0;
                    end
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_wait = '0;
            end
        endcase

        n_out.running_valid     = n_cur_valid;
        n_out.running_id        = n_cur.id;
        n_out.running_arrival   = n_cur.arrival;
        n_out.running_total     = n_cur.total;
        n_out.running_start     = n_cur_start;
        n_out.running_end       = n_cur_end;
        n_out.running_remaining = n_cur.remaining;
        n_out.running_priority  = n_cur.prio;
        n_out.queue_count       = 5'(n_count);
        n_out.overflow          = w_ovf;
    end

    // Control and running record registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_cur_valid <= 1'b0;
            r_cur       <= '0;
            r_cur_start <= '0;
            r_cur_end   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_cur_valid <= n_cur_valid;
            r_cur       <= n_cur;
            r_cur_start <= n_cur_start;
            r_cur_end   <= n_cur_end;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_now <= n_now;
        if (w_accept || w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Checks.
    `PPSCH_NEVER(a_count_bound, i_clk, i_rst_n, r_count > L_FULL)
    `PPSCH_ASSERT(a_complete_searches, i_clk, i_rst_n,
        (w_accept && (i_in.opcode == OP_COMPLETE)) |=> (r_state == S_SEARCH))
    `PPSCH_ASSERT(a_overflow_full, i_clk, i_rst_n,
        (r_out_valid && r_out.overflow) |-> (r_count == L_FULL))
    `PPSCH_ASSERT(a_idle_null, i_clk, i_rst_n,
        (r_out_valid && !r_out.running_valid) |->
        ((r_out.running_id == 16'd0) && (r_out.running_priority == 8'd0)))
    `PPSCH_ASSERT(a_dispatch_pops, i_clk, i_rst_n,
        (w_commit && w_tok[QUEUE_DEPTH].found) |=>
        (r_count == $past(r_count) - 1'b1))

endmodule

[rtl/core/ppsch_cell.sv]
module ppsch_cell
    import ppsch_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_qcmd                      i_cmd,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    input  logic [$clog2(DEPTH)-1:0]   i_sel_idx,
    input  t_entry                     i_push_entry,
    input  t_entry                     i_next_entry,
    output t_entry                     o_entry,
    input  t_tok                       i_tok,
    input  logic [$clog2(DEPTH)-1:0]   i_tok_idx,
    output t_tok                       o_tok,
    output logic [$clog2(DEPTH)-1:0]   o_tok_idx
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] L_POS = CW'(IDX);
    localparam logic [IW-1:0] L_IDX = IW'(IDX);

    t_entry          r_entry;
    t_tok            r_tok;
    t_tok            n_tok;
    logic [IW-1:0]   r_tok_idx;
    logic [IW-1:0]   n_tok_idx;
    logic            w_occupied;

    assign w_occupied = (L_POS < i_count);

    // Entry storage: a push lands at the tail, a removal pulls from the right neighbor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && (L_POS == i_count)) begin
            r_entry <= i_push_entry;
        end else if (i_cmd.shift && (L_IDX >= i_sel_idx)) begin
            r_entry <= i_next_entry;
        end
    end

    // The token keeps the earliest entry of lowest priority value seen so far.
    always_comb begin
        n_tok     = i_tok;
        n_tok_idx = i_tok_idx;
        if (w_occupied && (!i_tok.found || (r_entry.prio < i_tok.entry.prio))) begin
            n_tok.found = 1'b1;
            n_tok.entry = r_entry;
            n_tok_idx   = L_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.found <= 1'b0;
        end else begin
            r_tok.found <= n_tok.found;
        end
        r_tok.entry <= n_tok.entry;
        r_tok_idx   <= n_tok_idx;
    end

    assign o_entry   = r_entry;
    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule

[tb/sv/ppsch_checker.sv]
module ppsch_checker
    import ppsch_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out,
    output int   o_errors,
    output int   o_pending
);

    // One process as the scheduler keeps it, running or waiting.
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [15:0] total;
        logic [15:0] remaining;
        logic [7:0]  urgency;
    } proc_t;

    // Scheduler state as this side tracks it.
    logic        busy;
    proc_t       running;
    logic [31:0] run_start;
    logic [31:0] run_end;
    proc_t       ready_list[$];

    // Running records still owed by the block, oldest first.
    t_out expected_results[$];

    int mismatches  = 0;
    int outstanding = 0;

    assign o_errors  = mismatches;
    assign o_pending = outstanding;

    // Put a process on the processor at the given time.
    function automatic void dispatch(proc_t p, logic [31:0] at);
        busy      = 1'b1;
        running   = p;
        run_start = at;
        run_end   = at + 32'(p.remaining);
    endfunction

    // Apply one scheduling event and return the running record after it.
    function automatic t_out schedule_event(t_in ev);
        t_out        res;
        proc_t       incoming;
        proc_t       preempted;
        logic [31:0] elapsed;
        int          best;
        logic        dropped;
        dropped            = 1'b0;
        incoming.id        = ev.new_id;
        incoming.arrival   = ev.new_arrival;
        incoming.total     = ev.new_total;
        incoming.remaining = ev.new_total;
        incoming.urgency   = ev.new_priority;
        if (ev.opcode == OP_ARRIVE) begin
            if (!busy) begin
                dispatch(incoming, ev.now);
            end else if (ready_list.size() >= QUEUE_DEPTH) begin
                // No room: the arriving process is lost, whether it waits or preempts.
                dropped = 1'b1;
            end else if (incoming.urgency >= running.urgency) begin
                ready_list.push_back(incoming);
            end else begin
                // Preemption charges the elapsed time, saturating at zero.
                elapsed   = ev.now - run_start;
                preempted = running;
                preempted.remaining = (elapsed >= 32'(running.remaining)) ?
                                      16'd0 : running.remaining - elapsed[15:0];
                ready_list.push_back(preempted);
                dispatch(incoming, ev.now);
            end
        end else if (ready_list.size() == 0) begin
            busy      = 1'b0;
            running   = '0;
            run_start = '0;
            run_end   = '0;
        end else begin
            // First entry of lowest priority value wins; ties go to the earlier entry.
            best = 0;
            for (int i = 1; i < ready_list.size(); i++) begin
                if (ready_list[i].urgency < ready_list[best].urgency) begin
                    best = i;
                end
            end
            dispatch(ready_list[best], ev.now);
            ready_list.delete(best);
        end
        res.running_valid     = busy;
        res.running_id        = running.id;
        res.running_arrival   = running.arrival;
        res.running_total     = running.total;
        res.running_start     = run_start;
        res.running_end       = run_end;
        res.running_remaining = running.remaining;
        res.running_priority  = running.urgency;
        res.queue_count       = 5'(ready_list.size());
        res.overflow          = dropped;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Track accepted events and compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : track
        t_out want;
        if (!i_rst_n) begin
            busy      = 1'b0;
            running   = '0;
            run_start = '0;
            run_end   = '0;
            ready_list.delete();
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(schedule_event(i_in));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no event outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("running_valid", want.running_valid, i_out.running_valid);
                    check_field("running_id", want.running_id, i_out.running_id);
                    check_field("running_arrival", want.running_arrival,
                                i_out.running_arrival);
                    check_field("running_total", want.running_total, i_out.running_total);
                    check_field("running_start", want.running_start, i_out.running_start);
                    check_field("running_end", want.running_end, i_out.running_end);
                    check_field("running_remaining", want.running_remaining,
                                i_out.running_remaining);
                    check_field("running_priority", want.running_priority,
                                i_out.running_priority);
                    check_field("queue_count", want.queue_count, i_out.queue_count);
                    check_field("overflow", want.overflow, i_out.overflow);
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

[tb/sv/tb_preemptive_priority_scheduler.sv]
module tb_preemptive_priority_scheduler;
    import ppsch_pkg::*;

    localparam int QUEUE_DEPTH      = Q_DEPTH_DEFAULT;
    localparam int RANDOM_PER_PHASE = 330;
    localparam int EPISODE_LEN      = 40;
    localparam int LONG_HOLD        = 300;
    localparam int DRAIN_CYCLES     = 2 * (QUEUE_DEPTH + 2) + 4;
    localparam int CYCLE_LIMIT      = 400000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    int chk_errors;
    int chk_pending;

    // Idle percentages per side, and long receiver hold requests.
    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int hold_requests = 0;
    int cycles        = 0;

    logic [31:0] sim_now = '0;

    preemptive_priority_scheduler #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data)
    );

    ppsch_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Give up if the run never finishes.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold whenever one is requested.
    initial begin : result_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    function automatic t_in make_event(logic op, logic [31:0] at, logic [15:0] id,
                                       logic [31:0] arr, logic [15:0] tot, logic [7:0] pri);
        t_in ev;
        ev.opcode       = op;
        ev.now          = at;
        ev.new_id       = id;
        ev.new_arrival  = arr;
        ev.new_total    = tot;
        ev.new_priority = pri;
        return ev;
    endfunction

    // Random event on a mostly advancing clock; small priorities give many ties.
    function automatic t_in random_event(int arrive_pct);
        t_in ev;
        if ($urandom_range(0, 19) == 0) begin
            sim_now = $urandom;
        end else begin
            sim_now = sim_now + $urandom_range(0, 4000);
        end
        ev.opcode       = ($urandom_range(0, 99) < arrive_pct) ? OP_ARRIVE : OP_COMPLETE;
        ev.now          = sim_now;
        ev.new_id       = 16'($urandom);
        ev.new_arrival  = ($urandom_range(0, 3) == 0) ? $urandom :
                          sim_now - $urandom_range(0, 1000);
        ev.new_total    = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                          16'($urandom_range(0, 3000));
        ev.new_priority = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
                          8'($urandom_range(0, 7));
        return ev;
    endfunction

    // Offer one event; called at a falling edge, returns at a falling edge.
    task automatic send_event(input t_in ev);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (chk_pending != 0);
    endtask

    initial begin : stimulus
        int arrive_pct;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        snd_idle_pct = 37;
        rcv_idle_pct = 65;

        // Completion while idle with an empty queue.
        send_event(make_event(OP_COMPLETE, '1, '1, '1, '1, '1));
        // Start from idle with all-ones fields; the end time wraps.
        send_event(make_event(OP_ARRIVE, 32'hFFFF_FFF0, '1, '1, '1, '1));
        // Equal priority waits.
        send_event(make_event(OP_ARRIVE, 32'h0, '0, '0, '0, 8'hFF));
        // Preemption across the timer wrap; elapsed exceeds the remaining time.
        send_event(make_event(OP_ARRIVE, 32'h0001_0000, 16'h1, 32'h0001_0000, 16'h5, 8'h0));
        // Tie on priority dispatches the head, then the queue runs dry.
        send_event(make_event(OP_COMPLETE, 32'h0001_0010, '0, '0, '0, '0));
        send_event(make_event(OP_COMPLETE, 32'h0001_0020, '0, '0, '0, '0));
        send_event(make_event(OP_COMPLETE, 32'h0001_0030, '0, '0, '0, '0));

        // Fill the queue behind a running process.
        send_event(make_event(OP_ARRIVE, 32'h0002_0000, 16'h100, 32'h0002_0000,
                              16'd50, 8'h10));
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            send_event(make_event(OP_ARRIVE, 32'h0002_0000 + 32'(i) * 100, 16'(16'h200 + i),
                                  32'h0002_0000, 16'(1000 + i),
                                  (i % 4 == 0) ? 8'h10 : 8'(8'h10 + i * 15)));
        end
        // Full queue: drop a waiting arrival, then a preempting one.
        send_event(make_event(OP_ARRIVE, 32'h0003_0000, 16'h300, 32'h0003_0000, 16'd7, 8'h20));
        send_event(make_event(OP_ARRIVE, 32'h0003_0010, 16'h301, 32'h0003_0010, 16'd7, 8'h00));
        // Dispatch, then preempt with time still left.
        send_event(make_event(OP_COMPLETE, 32'h0004_0000, '0, '0, '0, '0));
        send_event(make_event(OP_ARRIVE, 32'h0004_0003, 16'h400, 32'h0004_0003,
                              16'd20, 8'h05));
        sim_now = 32'h0004_0003;

        // Random phases: receiver idles more, then sender idles more, then neither idles at random.
        for (int phase = 0; phase < 3; phase++) begin
            if (phase > 0) begin
                drain_results();
            end
            snd_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 65 : 0;
            rcv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 37 : 0;
            if (phase == 2) begin
                hold_requests++;
            end
            arrive_pct = 55;
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Bias each stretch toward filling, steady, or draining the queue.
                if (n % EPISODE_LEN == 0) begin
                    case ($urandom_range(0, 2))
                        0: arrive_pct = 35;
                        1: arrive_pct = 55;
                        default: arrive_pct = 85;
                    endcase
                end
                send_event(random_event(arrive_pct));
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (chk_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/ppsch_pkg.sv
rtl/core/ppsch_cell.sv
rtl/core/preemptive_priority_scheduler.sv
tb/sv/ppsch_checker.sv
tb/sv/tb_preemptive_priority_scheduler.sv
